// ===== src/sparse_set_engine_assert.svh =====
// Assertion macros for the sparse set engine.
// SSE_ASSERT checks a property outside reset; SSE_ASSERT_RST also checks it while reset is held.
`ifndef SPARSE_SET_ENGINE_ASSERT_SVH
`define SPARSE_SET_ENGINE_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define SSE_ASSERT_RST(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define SSE_ASSERT(lbl, clk, rst_n, prop, msg)
`define SSE_ASSERT_RST(lbl, clk, prop, msg)
`endif
`endif

// ===== src/sse_pkg.sv =====
`timescale 1ns / 1ps

package sse_pkg;

    // Default size of the value universe.
    localparam int unsigned UNIVERSE_DEF = 1024;

    // Width of the epoch tag kept with each value; tag zero means "not a member".
    localparam int unsigned TAG_W = 6;

    // Widths of the item fields.
    localparam int unsigned CMD_W     = 3;
    localparam int unsigned OPND_W    = 16;
    localparam int unsigned STATUS_W  = 2;
    localparam int unsigned VAL_OUT_W = 10;
    localparam int unsigned POS_OUT_W = 10;
    localparam int unsigned CNT_OUT_W = 11;

    // Commands.
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_READ   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd4;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd3;

endpackage

// ===== src/sse_ram.sv =====
`timescale 1ns / 1ps

module sse_ram #(
    parameter int unsigned DEPTH = sse_pkg::UNIVERSE_DEF,
    parameter int unsigned WIDTH = sse_pkg::VAL_OUT_W
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/sparse_set_engine.sv =====
`timescale 1ns / 1ps
`include "sparse_set_engine_assert.svh"

// Sparse set over the values 0 to UNIVERSE-1, held in two single-port-write memories with a
// registered read: a dense element memory indexed by position and a value memory indexed by
// value that holds each member's position and an epoch tag. An item is taken when start is
// high and busy is low. Insert, read, find and clear pass through the accept cycle and the
// memory read cycle (S_IDLE, then S_EXEC); remove also passes S_TAGW, as its second write to
// the value memory must wait for that memory's only write port. The result is registered out
// of S_EXEC and shown for exactly one cycle with o_valid high; the receiver cannot stall
// and must capture it then. Clear bumps the epoch tag, so it empties the set at once; after
// reset, and again on every 63rd clear when the tag wraps, a clearing pass (S_WIPE) rewrites
// every word of the value memory while busy stays high.
module sparse_set_engine #(
    parameter int unsigned UNIVERSE = sse_pkg::UNIVERSE_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [sse_pkg::CMD_W-1:0]     i_command,
    input  logic [sse_pkg::OPND_W-1:0]    i_operand,
    output logic                          o_valid,
    output logic [sse_pkg::STATUS_W-1:0]  o_status,
    output logic [sse_pkg::VAL_OUT_W-1:0] o_result_value,
    output logic [sse_pkg::POS_OUT_W-1:0] o_result_position,
    output logic [sse_pkg::CNT_OUT_W-1:0] o_member_count
);

    localparam int unsigned IDX_W = $clog2(UNIVERSE);
    localparam int unsigned CNT_W = $clog2(UNIVERSE + 1);
    localparam int unsigned TAG_W = sse_pkg::TAG_W;
    localparam int unsigned VM_W  = TAG_W + IDX_W;
    localparam int unsigned OPX_W = sse_pkg::OPND_W + 1;
    localparam int unsigned VO_W  = sse_pkg::VAL_OUT_W;
    localparam int unsigned PO_W  = sse_pkg::POS_OUT_W;
    localparam int unsigned CO_W  = sse_pkg::CNT_OUT_W;
    localparam logic [OPX_W-1:0] UNI_X     = OPX_W'(UNIVERSE);
    localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(UNIVERSE);
    localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(UNIVERSE - 1);
    localparam logic [TAG_W-1:0] TAG_FIRST = TAG_W'(1);
    localparam logic [TAG_W-1:0] TAG_LAST  = {TAG_W{1'b1}};

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_TAGW = 4'b0100,
        S_WIPE = 4'b1000
    } t_state;

    t_state                        r_state, n_state;
    logic [sse_pkg::CMD_W-1:0]     r_cmd;
    logic [sse_pkg::OPND_W-1:0]    r_opnd;
    logic [CNT_W-1:0]              r_count, n_count;
    logic [TAG_W-1:0]              r_epoch, n_epoch;
    logic [IDX_W-1:0]              r_wipe_idx, n_wipe_idx;
    logic                          r_valid, n_valid;
    logic [sse_pkg::STATUS_W-1:0]  r_status, n_status;
    logic [VO_W-1:0]               r_res_val, n_res_val;
    logic [PO_W-1:0]               r_res_pos, n_res_pos;
    logic [CO_W-1:0]               r_res_cnt;

    logic             accept;
    logic             in_range;
    logic             pos_valid;
    logic [IDX_W-1:0] v_idx;

    // Element memory: position -> value.
    logic             el_we, el_re;
    logic [IDX_W-1:0] el_waddr, el_wdata, el_raddr, el_rdata;

    // Value memory: value -> {epoch tag, position}.
    logic             vm_we, vm_re;
    logic [IDX_W-1:0] vm_waddr, vm_raddr;
    logic [VM_W-1:0]  vm_wdata, vm_rdata;
    logic [TAG_W-1:0] vm_tag;
    logic [IDX_W-1:0] vm_pos;
    logic             member;

    sse_ram #(.DEPTH(UNIVERSE), .WIDTH(IDX_W)) u_elem_ram (
        .i_clk   (i_clk),
        .i_we    (el_we),
        .i_waddr (el_waddr),
        .i_wdata (el_wdata),
        .i_re    (el_re),
        .i_raddr (el_raddr),
        .o_rdata (el_rdata)
    );

    sse_ram #(.DEPTH(UNIVERSE), .WIDTH(VM_W)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (vm_we),
        .i_waddr (vm_waddr),
        .i_wdata (vm_wdata),
        .i_re    (vm_re),
        .i_raddr (vm_raddr),
        .o_rdata (vm_rdata)
    );

    assign busy   = (r_state != S_IDLE);
    assign accept = start && !busy;

    // Both reads are issued in the accept cycle. For every command but read, the element
    // memory fetches the last element, which remove needs to fill its hole.
    assign el_re    = accept;
    assign vm_re    = accept;
    assign vm_raddr = i_operand[IDX_W-1:0];
    assign el_raddr = (i_command == sse_pkg::CMD_READ) ? i_operand[IDX_W-1:0]
                                                       : IDX_W'(r_count - 1'b1);

    assign v_idx     = r_opnd[IDX_W-1:0];
    assign in_range  = {1'b0, r_opnd} < UNI_X;
    assign pos_valid = {1'b0, r_opnd} < OPX_W'(r_count);
    assign vm_tag    = vm_rdata[VM_W-1:IDX_W];
    assign vm_pos    = vm_rdata[IDX_W-1:0];
    assign member    = (vm_tag == r_epoch);

    always_comb begin
        n_state    = r_state;
        n_count    = r_count;
        n_epoch    = r_epoch;
        n_wipe_idx = r_wipe_idx;
        n_valid    = 1'b0;
        n_status   = sse_pkg::ST_DONE;
        n_res_val  = r_opnd[VO_W-1:0];
        n_res_pos  = '0;
        el_we      = 1'b0;
        el_waddr   = IDX_W'(r_count);
        el_wdata   = v_idx;
        vm_we      = 1'b0;
        vm_waddr   = v_idx;
        vm_wdata   = {r_epoch, IDX_W'(r_count)};

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_valid = 1'b1;
                n_state = S_IDLE;
                unique case (r_cmd)
                    sse_pkg::CMD_INSERT: begin
                        if (!in_range) begin
                            n_status = sse_pkg::ST_RANGE;
                        end else if (member) begin
                            n_status  = sse_pkg::ST_SAME;
                            n_res_pos = PO_W'(vm_pos);
                        end else if (r_count == CNT_FULL) begin
                            n_status = sse_pkg::ST_RANGE;
                        end else begin
                            el_we     = 1'b1;
                            vm_we     = 1'b1;
                            n_count   = CNT_W'(r_count + 1'b1);
                            n_res_pos = PO_W'(r_count);
                        end
                    end
                    sse_pkg::CMD_REMOVE: begin
                        if (!in_range) begin
                            n_status = sse_pkg::ST_RANGE;
                        end else if (!member || r_count == '0) begin
                            n_status = sse_pkg::ST_ABSENT;
                        end else begin
                            // The last element fills the hole; the removed value's tag is
                            // dropped in the following cycle.
                            el_we    = 1'b1;
                            el_waddr = vm_pos;
                            el_wdata = el_rdata;
                            vm_we    = 1'b1;
                            vm_waddr = el_rdata;
                            vm_wdata = {r_epoch, vm_pos};
                            n_count  = CNT_W'(r_count - 1'b1);
                            n_state  = S_TAGW;
                        end
                    end
                    sse_pkg::CMD_READ: begin
                        if (pos_valid) begin
                            n_res_val = VO_W'(el_rdata);
                        end else begin
                            n_status  = sse_pkg::ST_ABSENT;
                            n_res_val = '0;
                        end
                    end
                    sse_pkg::CMD_FIND: begin
                        if (!in_range) begin
                            n_status = sse_pkg::ST_RANGE;
                        end else if (!member) begin
                            n_status = sse_pkg::ST_ABSENT;
                        end else begin
                            n_res_pos = PO_W'(vm_pos);
                        end
                    end
                    sse_pkg::CMD_CLEAR: begin
                        n_count   = '0;
                        n_res_val = '0;
                        if (r_epoch == TAG_LAST) begin
                            // The tag would wrap and revive stale members: wipe first.
                            n_epoch    = TAG_FIRST;
                            n_wipe_idx = '0;
                            n_state    = S_WIPE;
                        end else begin
                            n_epoch = TAG_W'(r_epoch + 1'b1);
                        end
                    end
                    default: begin
                        n_status = sse_pkg::ST_RANGE;
                    end
                endcase
            end
            S_TAGW: begin
                vm_we    = 1'b1;
                vm_wdata = '0;
                n_state  = S_IDLE;
            end
            S_WIPE: begin
                vm_we    = 1'b1;
                vm_waddr = r_wipe_idx;
                vm_wdata = '0;
                if (r_wipe_idx == IDX_LAST) begin
                    n_state = S_IDLE;
                end else begin
                    n_wipe_idx = IDX_W'(r_wipe_idx + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_WIPE;
            r_count    <= '0;
            r_epoch    <= TAG_FIRST;
            r_wipe_idx <= '0;
            r_valid    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_count    <= n_count;
            r_epoch    <= n_epoch;
            r_wipe_idx <= n_wipe_idx;
            r_valid    <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd  <= i_command;
            r_opnd <= i_operand;
        end
        if (n_valid) begin
            r_status  <= n_status;
            r_res_val <= n_res_val;
            r_res_pos <= n_res_pos;
            r_res_cnt <= CO_W'(n_count);
        end
    end

    assign o_valid           = r_valid;
    assign o_status          = r_status;
    assign o_result_value    = r_res_val;
    assign o_result_position = r_res_pos;
    assign o_member_count    = r_res_cnt;

    `SSE_ASSERT(a_one_result, i_clk, i_rst_n, accept |-> ##2 r_valid, "item gave no result")
    `SSE_ASSERT(a_no_double, i_clk, i_rst_n, r_valid |=> !r_valid, "two results in a row")
    `SSE_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= CNT_FULL, "count beyond universe")
    `SSE_ASSERT(a_epoch_live, i_clk, i_rst_n, r_epoch != '0, "epoch tag reached zero")
    `SSE_ASSERT_RST(a_reset_quiet, i_clk, !i_rst_n |=> (!r_valid && busy), "reset not quiet")

endmodule
